### rtl/ild_pkg.sv
// Shared types, codes and decode tables for the instruction length decoder.
package ild_pkg;

    typedef struct packed {
        logic [47:0] instr_bytes;
        logic [3:0]  avail_bytes;
    } req_t;

    typedef struct packed {
        logic [3:0] instr_length;
        logic [6:0] mnemonic;
        logic [3:0] layout;
        logic       known;
    } rsp_t;

    typedef struct packed {
        logic [3:0] len_s;
        logic [3:0] len_l;
        logic [6:0] mn;
        logic [3:0] lay;
    } entry_t;

    localparam logic [6:0] MN_NONE = 7'd0;
    localparam logic [6:0] MN_JMP_EXEC_ANY = 7'd1, MN_JMP_INCOMPLETE = 7'd2, MN_TRAP = 7'd3;
    localparam logic [6:0] MN_CALL = 7'd4, MN_JMP_EXEC_NONE = 7'd5, MN_WAIT = 7'd6;
    localparam logic [6:0] MN_WAIT_PIX = 7'd7, MN_SIGNAL_PIX = 7'd8, MN_TG_BARRIER = 7'd9;
    localparam logic [6:0] MN_STOP = 7'd10, MN_ST_TILE = 7'd11, MN_ST_VAR = 7'd12;
    localparam logic [6:0] MN_ST_VAR_FINAL = 7'd13, MN_LD_VAR = 7'd14, MN_TG_STORE = 7'd15;
    localparam logic [6:0] MN_TEX_SAMPLE = 7'd16, MN_LD_TILE = 7'd17, MN_NO_VAR = 7'd18;
    localparam logic [6:0] MN_LD_VAR_PERSP = 7'd19, MN_TG_LOAD = 7'd20, MN_TEX_LOAD = 7'd21;
    localparam logic [6:0] MN_FCMPSEL = 7'd22, MN_FLOOR = 7'd23, MN_ICMPSEL = 7'd24;
    localparam logic [6:0] MN_FMUL = 7'd25, MN_FCMP_BALLOT = 7'd26, MN_FADD = 7'd27;
    localparam logic [6:0] MN_ICMP_BALLOT = 7'd28, MN_FMADD = 7'd29, MN_IF_FCMP = 7'd30;
    localparam logic [6:0] MN_FLOOR_SAT = 7'd31, MN_POP_EXEC = 7'd32, MN_FMUL_SAT = 7'd33;
    localparam logic [6:0] MN_MOV = 7'd34, MN_FADD_SAT = 7'd35, MN_GET_SR = 7'd36;
    localparam logic [6:0] MN_FMADD_SAT = 7'd37, MN_RET = 7'd38, MN_DEVICE_LOAD = 7'd39;
    localparam logic [6:0] MN_STACK_LOAD = 7'd40, MN_DEVICE_STORE = 7'd41;
    localparam logic [6:0] MN_STACK_STORE = 7'd42, MN_IADD = 7'd43, MN_FMUL16 = 7'd44;
    localparam logic [6:0] MN_IMADD = 7'd45, MN_FADD16 = 7'd46, MN_BITFIELD = 7'd47;
    localparam logic [6:0] MN_FMADD16 = 7'd48, MN_CONVERT = 7'd49, MN_BITWISE = 7'd50;
    localparam logic [6:0] MN_IADD_SAT = 7'd51, MN_FMUL16_SAT = 7'd52, MN_IMADD_SAT = 7'd53;
    localparam logic [6:0] MN_FADD16_SAT = 7'd54, MN_FMADD16_SAT = 7'd55, MN_ZERO = 7'd56;
    localparam logic [6:0] MN_NANDN = 7'd57, MN_ANDN = 7'd58, MN_NOT = 7'd59;
    localparam logic [6:0] MN_NAND = 7'd60, MN_XOR = 7'd61, MN_ANY_FALSE = 7'd62;
    localparam logic [6:0] MN_AND = 7'd63, MN_XNOR = 7'd64, MN_ANY_TRUE = 7'd65;
    localparam logic [6:0] MN_ALL_FALSE = 7'd66, MN_ALL_TRUE = 7'd67, MN_ONE = 7'd68;

    localparam logic [3:0] LY_NONE = 4'd0, LY_R1 = 4'd1, LY_R2 = 4'd2, LY_ALU3 = 4'd3;
    localparam logic [3:0] LY_ALU4 = 4'd4, LY_MOVI_S = 4'd5, LY_MOVI_L = 4'd6;
    localparam logic [3:0] LY_MEM = 4'd7, LY_DST = 4'd8, LY_DST_S2 = 4'd9;
    localparam logic [3:0] LY_DST_S1 = 4'd10;

    function automatic entry_t grp1_entry(input logic [3:0] idx);
        entry_t e;
        case (idx)
            4'd1:    e = '{4'd8, 4'd8,  MN_ST_TILE,      LY_R1};
            4'd2:    e = '{4'd4, 4'd4,  MN_ST_VAR,       LY_R2};
            4'd4:    e = '{4'd4, 4'd8,  MN_LD_VAR,       LY_R2};
            4'd5:    e = '{4'd6, 4'd8,  MN_TG_STORE,     LY_NONE};
            4'd6:    e = '{4'd8, 4'd12, MN_TEX_SAMPLE,   LY_NONE};
            4'd7:    e = '{4'd6, 4'd8,  MN_TG_STORE,     LY_NONE};
            4'd9:    e = '{4'd8, 4'd8,  MN_LD_TILE,      LY_R1};
            4'd10:   e = '{4'd4, 4'd4,  MN_NO_VAR,       LY_NONE};
            4'd12:   e = '{4'd4, 4'd8,  MN_LD_VAR_PERSP, LY_R2};
            4'd13:   e = '{4'd6, 4'd8,  MN_TG_LOAD,      LY_NONE};
            4'd14:   e = '{4'd8, 4'd12, MN_TEX_LOAD,     LY_NONE};
            4'd15:   e = '{4'd6, 4'd8,  MN_TG_LOAD,      LY_NONE};
            default: e = '{4'd8, 4'd8,  MN_NONE,         LY_NONE};
        endcase
        return e;
    endfunction

    function automatic entry_t grp2_entry(input logic [3:0] idx);
        entry_t e;
        case (idx)
            4'd0:    e = '{4'd8, 4'd10, MN_FCMPSEL,     LY_NONE};
            4'd1:    e = '{4'd4, 4'd6,  MN_FLOOR,       LY_NONE};
            4'd2:    e = '{4'd8, 4'd10, MN_ICMPSEL,     LY_NONE};
            4'd3:    e = '{4'd6, 4'd6,  MN_FMUL,        LY_ALU3};
            4'd4:    e = '{4'd8, 4'd8,  MN_FCMP_BALLOT, LY_NONE};
            4'd5:    e = '{4'd6, 4'd6,  MN_FADD,        LY_ALU3};
            4'd6:    e = '{4'd8, 4'd8,  MN_ICMP_BALLOT, LY_NONE};
            4'd7:    e = '{4'd8, 4'd8,  MN_FMADD,       LY_ALU4};
            4'd8:    e = '{4'd6, 4'd6,  MN_IF_FCMP,     LY_NONE};
            4'd9:    e = '{4'd4, 4'd6,  MN_FLOOR_SAT,   LY_NONE};
            4'd10:   e = '{4'd6, 4'd6,  MN_POP_EXEC,    LY_NONE};
            4'd11:   e = '{4'd6, 4'd6,  MN_FMUL_SAT,    LY_ALU3};
            4'd12:   e = '{4'd4, 4'd6,  MN_MOV,         LY_MOVI_S};
            4'd13:   e = '{4'd6, 4'd6,  MN_FADD_SAT,    LY_ALU3};
            4'd14:   e = '{4'd4, 4'd4,  MN_GET_SR,      LY_NONE};
            default: e = '{4'd8, 4'd8,  MN_FMADD_SAT,   LY_ALU4};
        endcase
        return e;
    endfunction

    function automatic entry_t grp6_entry(input logic [3:0] idx);
        entry_t e;
        case (idx)
            4'd1:    e = '{4'd8, 4'd8, MN_IADD,        LY_ALU3};
            4'd2:    e = '{4'd6, 4'd6, MN_FMUL16,      LY_ALU3};
            4'd3:    e = '{4'd8, 4'd8, MN_IMADD,       LY_ALU4};
            4'd4:    e = '{4'd6, 4'd6, MN_FADD16,      LY_ALU3};
            4'd5:    e = '{4'd8, 4'd8, MN_BITFIELD,    LY_NONE};
            4'd6:    e = '{4'd6, 4'd8, MN_FMADD16,     LY_ALU4};
            4'd7:    e = '{4'd6, 4'd6, MN_BITWISE,     LY_NONE};
            4'd9:    e = '{4'd8, 4'd8, MN_IADD_SAT,    LY_ALU3};
            4'd10:   e = '{4'd6, 4'd6, MN_FMUL16_SAT,  LY_ALU3};
            4'd11:   e = '{4'd8, 4'd8, MN_IMADD_SAT,   LY_ALU4};
            4'd12:   e = '{4'd6, 4'd6, MN_FADD16_SAT,  LY_ALU3};
            4'd14:   e = '{4'd6, 4'd8, MN_FMADD16_SAT, LY_ALU4};
            4'd15:   e = '{4'd6, 4'd6, MN_NONE,        LY_NONE};
            default: e = '{4'd2, 4'd2, MN_NONE,        LY_NONE};
        endcase
        return e;
    endfunction

    // Bitwise-op truth table code -> {mnemonic, layout}
    function automatic logic [10:0] logic_entry(input logic [3:0] code);
        logic [10:0] r;
        case (code)
            4'd0:    r = {MN_ZERO,      LY_DST};
            4'd1:    r = {MN_NANDN,     LY_ALU3};
            4'd2:    r = {MN_ANDN,      LY_ALU3};
            4'd3:    r = {MN_NOT,       LY_DST_S2};
            4'd4:    r = {MN_NAND,      LY_ALU3};
            4'd5:    r = {MN_NOT,       LY_DST_S1};
            4'd6:    r = {MN_XOR,       LY_ALU3};
            4'd7:    r = {MN_ANY_FALSE, LY_ALU3};
            4'd8:    r = {MN_AND,       LY_ALU3};
            4'd9:    r = {MN_XNOR,      LY_ALU3};
            4'd10:   r = {MN_MOV,       LY_DST_S1};
            4'd11:   r = {MN_ANY_TRUE,  LY_ALU3};
            4'd12:   r = {MN_MOV,       LY_DST_S2};
            4'd13:   r = {MN_ALL_FALSE, LY_ALU3};
            4'd14:   r = {MN_ALL_TRUE,  LY_ALU3};
            default: r = {MN_ONE,       LY_DST};
        endcase
        return r;
    endfunction

endpackage

### rtl/ild_decode.sv
// Combinational classifier: byte masking, group decode and table lookups.
module ild_decode
    import ild_pkg::*;
(
    input  req_t req,
    output rsp_t rsp
);

    logic [7:0] b [6];
    logic [7:0] b0;
    logic [3:0] idx;
    logic       lng;
    entry_t     e;
    logic [3:0] len;
    logic [6:0] mn;
    logic [3:0] lay;
    logic [3:0] code;

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            b[i] = (4'(i) < req.avail_bytes) ? req.instr_bytes[8*i +: 8] : 8'h00;
        end
    end

    assign b0   = b[0];
    assign idx  = b0[6:3];
    assign lng  = b[1][7];
    assign code = {b[4][7:6], b[3][3:2]};

    always_comb
    begin
        len = 4'd2;
        mn  = MN_NONE;
        lay = LY_NONE;
        e   = '0;
        case (b0[2:0])
            3'd0:
            begin
                case (b0)
                    8'h00:
                    begin
                        len = lng ? 4'd6 : 4'd4;
                        mn  = lng ? MN_JMP_EXEC_ANY : MN_JMP_INCOMPLETE;
                    end
                    8'h08:   mn = MN_TRAP;
                    8'h10:
                    begin
                        len = 4'd6;
                        mn  = MN_CALL;
                    end
                    8'h20:
                    begin
                        len = 4'd6;
                        mn  = MN_JMP_EXEC_NONE;
                    end
                    8'h38:   mn = MN_WAIT;
                    8'h48:
                    begin
                        len = 4'd4;
                        mn  = MN_WAIT_PIX;
                    end
                    8'h58:
                    begin
                        len = 4'd4;
                        mn  = MN_SIGNAL_PIX;
                    end
                    8'h68:   mn = MN_TG_BARRIER;
                    8'h88:   mn = MN_STOP;
                    default: mn = MN_NONE;
                endcase
            end
            3'd1:
            begin
                e   = grp1_entry(idx);
                len = lng ? e.len_l : e.len_s;
                mn  = (idx == 4'd2 && b0[7]) ? MN_ST_VAR_FINAL : e.mn;
                lay = e.lay;
            end
            3'd2:
            begin
                e = grp2_entry(idx);
                if (idx == 4'd12 && b[1][0])
                begin
                    e.len_s = 4'd6;
                    e.len_l = 4'd8;
                    e.lay   = LY_MOVI_L;
                end
                len = lng ? e.len_l : e.len_s;
                mn  = e.mn;
                lay = e.lay;
            end
            3'd3:    len = 4'd2;
            3'd4:
            begin
                if (idx == 4'd0)
                begin
                    mn = MN_CALL;
                end
                else if (idx == 4'd2)
                begin
                    mn = MN_RET;
                end
            end
            3'd5:
            begin
                // memory group takes its long-form bit from byte 5
                len = b[5][7] ? 4'd8 : 4'd6;
                case (b0 & 8'hFD)
                    8'h05, 8'h85:
                    begin
                        mn  = MN_DEVICE_LOAD;
                        lay = LY_MEM;
                    end
                    8'h35:   mn = MN_STACK_LOAD;
                    8'h45, 8'hC5:
                    begin
                        mn  = MN_DEVICE_STORE;
                        lay = LY_MEM;
                    end
                    8'hB5:   mn = MN_STACK_STORE;
                    default: mn = MN_NONE;
                endcase
            end
            3'd6:
            begin
                e   = grp6_entry(idx);
                len = lng ? e.len_l : e.len_s;
                mn  = e.mn;
                lay = e.lay;
                if (idx == 4'd7 && lng)
                begin
                    mn = MN_CONVERT;
                end
                if (idx == 4'd15)
                begin
                    {mn, lay} = logic_entry(code);
                end
            end
            3'd7:    len = 4'd6;
            default: len = 4'd2;
        endcase
    end

    assign rsp.instr_length = len;
    assign rsp.mnemonic     = mn;
    assign rsp.layout       = lay;
    assign rsp.known        = (mn != MN_NONE);

endmodule

### rtl/gpu_g13_instruction_length_decoder.sv
// Top level: input register, decode logic and result register with stall control.
// Decodes one instruction per clock while rsp is not stalled. An accepted beat
// moves from the input register to the result register and is then shown on rsp.
// The path is an input register, one pass of table and pattern-match logic, and a
// result register; req_stall rises only when both registers hold beats and rsp is
// stalled.
module gpu_g13_instruction_length_decoder
    import ild_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    logic s1_valid_reg;
    logic s1_valid_next;
    req_t s1_req_reg;
    logic out_valid_reg;
    logic out_valid_next;
    rsp_t out_rsp_reg;
    rsp_t dec_rsp;
    logic out_load;
    logic s1_load;

    ild_decode u_decode (
        .req (s1_req_reg),
        .rsp (dec_rsp)
    );

    assign out_load       = !out_valid_reg || !rsp_stall;
    assign req_stall      = s1_valid_reg && !out_load;
    assign s1_load        = req_valid && !req_stall;
    assign s1_valid_next  = s1_load || (s1_valid_reg && !out_load);
    assign out_valid_next = out_load ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_req_reg <= req;
        end
        if (out_load && s1_valid_reg)
        begin
            out_rsp_reg <= dec_rsp;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_rsp_reg;

    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (s1_valid_reg && out_valid_reg && rsp_stall))
        else $error("req stalled without a full pipeline");

    a_known_matches: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.known == (rsp.mnemonic != MN_NONE)))
        else $error("known flag disagrees with mnemonic");

    a_length_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (!rsp.instr_length[0] && rsp.instr_length >= 4'd2
                       && rsp.instr_length <= 4'd12))
        else $error("instruction length out of range or odd");

    a_beat_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_load) |=> out_valid_reg)
        else $error("decoded beat lost between stages");

endmodule
